[src/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the sorted priority queue and its cell chain
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int unsigned KEY_W = 8;
    localparam int unsigned ID_W  = 16;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [ID_W-1:0]  t_id;

    // request codes
    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_POP      = 2'd1,
        REQ_REMOVE   = 2'd2,
        REQ_CONTAINS = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    // operation broadcast to every cell
    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,
        OP_INSERT = 3'd1,
        OP_POP    = 3'd2,
        OP_MATCH  = 3'd3,
        OP_PROP   = 3'd4,
        OP_REMOVE = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_key key;
        t_id  id;
    } t_entry;

    typedef struct packed {
        t_cell_op op;
        t_key     key;
        t_id      id;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

endpackage

`default_nettype wire

[src/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the queue: holds an entry, compares it, trades with neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell import spq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  t_entry    i_lower,
    input  logic      i_lower_t,
    input  t_entry    i_upper,
    input  logic      i_upper_above,
    output t_entry    o_entry,
    output logic      o_t,
    output logic      o_above
);

    t_entry r_entry;
    t_entry n_entry;
    t_entry new_entry;
    logic   r_hit;
    logic   r_above;

    // slot is free or holds a strictly higher key: new entry goes at or below
    assign o_t       = !i_occ || (r_entry.key > i_ctl.key);
    assign o_above   = r_above || r_hit;
    assign o_entry   = r_entry;
    assign new_entry = '{key: i_ctl.key, id: i_ctl.id};

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.op)
            OP_INSERT: begin
                if (o_t) begin
                    n_entry = i_lower_t ? i_lower : new_entry;
                end
            end
            OP_POP: begin
                n_entry = i_upper;
            end
            OP_REMOVE: begin
                // at and above the head-most match, close the gap
                if (!r_above) begin
                    n_entry = i_upper;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit   <= 1'b0;
            r_above <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                OP_MATCH: begin
                    r_hit   <= i_occ && (r_entry.id == i_ctl.id);
                    r_above <= 1'b0;
                end
                OP_PROP: begin
                    r_above <= i_upper_above;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[src/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue
// sorted priority queue built as a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// Holds up to CAPACITY (id, priority) entries kept in priority order. A
// request is taken at a clock edge where start is high and busy is low. Its
// single result appears on the o_ ports with o_valid high for exactly one
// cycle, and the receiver cannot stall it. Insert and pop answer in the cycle
// right after the request is taken, and the next request may follow at once.
// Remove and contains (on a non-empty queue) hold busy high through the scan
// and apply states after the request is taken and answer in the cycle after
// the apply state, taking no new request meanwhile: the match flag walks
// down the cell chain one cell per clock to find the head-most hit.
// Insert on a full queue, pop or remove on an empty one, and remove of an id
// not held leave the contents alone and report it in o_status.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_req_type,
    input  logic [ID_W-1:0]                    i_proc_id,
    input  logic [KEY_W-1:0]                   i_priority_req,
    output logic                               o_valid,
    output logic [ID_W-1:0]                    o_out_id,
    output logic [KEY_W-1:0]                   o_out_priority,
    output logic [1:0]                         o_status,
    output logic                               o_found,
    output logic [$clog2(CAPACITY+1)-1:0]      o_occupancy
);

    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned STEP_W = $clog2(CAPACITY);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CAPACITY - 2);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);

    // layout: cell 0 is the tail (lowest priority), cell count-1 the head

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [STEP_W-1:0] r_step, n_step;
    t_req              r_req, n_req;

    logic              r_valid;
    t_id               r_out_id;
    t_key              r_out_pri;
    t_status           r_status;
    logic              r_found;

    logic              res_valid;
    t_id               res_id;
    t_key              res_pri;
    t_status           res_status;
    logic              res_found;

    t_cell_ctl         ctl;
    t_entry            w_entry [CAPACITY];
    logic              w_t     [CAPACITY];
    logic              w_above [CAPACITY];

    logic              is_empty;
    logic              is_full;
    logic              hit_any;

    assign busy     = (r_state != S_IDLE);
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CNT_FULL);
    // after the walk, cell 0 sees whether any occupied cell matched
    assign hit_any  = w_above[0];

    // ---------------- cell chain ----------------
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(j);
        t_entry lower_e;
        logic   lower_t;
        t_entry upper_e;
        logic   upper_above;

        if (j == 0) begin : g_tail
            assign lower_e = '0;
            assign lower_t = 1'b0;
        end else begin : g_mid_lo
            assign lower_e = w_entry[j-1];
            assign lower_t = w_t[j-1];
        end

        if (j == CAPACITY - 1) begin : g_top
            assign upper_e     = '0;
            assign upper_above = 1'b0;
        end else begin : g_mid_hi
            assign upper_e     = w_entry[j+1];
            assign upper_above = w_above[j+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_occ         (IDX < r_count),
            .i_lower       (lower_e),
            .i_lower_t     (lower_t),
            .i_upper       (upper_e),
            .i_upper_above (upper_above),
            .o_entry       (w_entry[j]),
            .o_t           (w_t[j]),
            .o_above       (w_above[j])
        );
    end

    // ---------------- request control ----------------
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_step     = r_step;
        n_req      = r_req;
        ctl        = '{op: OP_HOLD, key: i_priority_req, id: i_proc_id};
        res_valid  = 1'b0;
        res_id     = '0;
        res_pri    = '0;
        res_status = STAT_OK;
        res_found  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = t_req'(i_req_type);
                    unique case (t_req'(i_req_type))
                        REQ_INSERT: begin
                            res_valid = 1'b1;
                            if (is_full) begin
                                res_status = STAT_FULL;
                            end else begin
                                ctl.op  = OP_INSERT;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        REQ_POP: begin
                            res_valid = 1'b1;
                            if (is_empty) begin
                                res_status = STAT_EMPTY;
                            end else begin
                                // tail sits in cell 0, whole chain slides down
                                ctl.op  = OP_POP;
                                n_count = r_count - CNT_W'(1);
                                res_id  = w_entry[0].id;
                                res_pri = w_entry[0].key;
                            end
                        end
                        REQ_REMOVE: begin
                            if (is_empty) begin
                                res_valid  = 1'b1;
                                res_status = STAT_EMPTY;
                            end else begin
                                ctl.op  = OP_MATCH;
                                n_step  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        REQ_CONTAINS: begin
                            if (is_empty) begin
                                res_valid = 1'b1;
                            end else begin
                                ctl.op  = OP_MATCH;
                                n_step  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // match flags ripple one cell toward the tail per cycle
                ctl.op = OP_PROP;
                if (r_step == STEP_LAST) begin
                    n_state = S_APPLY;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_APPLY: begin
                res_valid = 1'b1;
                n_state   = S_IDLE;
                if (r_req == REQ_REMOVE) begin
                    if (hit_any) begin
                        ctl.op  = OP_REMOVE;
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        res_status = STAT_NOT_FOUND;
                    end
                end else begin
                    res_found = hit_any;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_req   <= REQ_INSERT;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_req   <= n_req;
            r_valid <= res_valid;
        end
    end

    // result payload, qualified by r_valid
    always_ff @(posedge i_clk) begin
        r_out_id  <= res_id;
        r_out_pri <= res_pri;
        r_status  <= res_status;
        r_found   <= res_found;
    end

    assign o_valid        = r_valid;
    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_pri;
    assign o_status       = r_status;
    assign o_found        = r_found;
    assign o_occupancy    = r_count;

endmodule

`default_nettype wire

[src/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks on the sorted priority queue
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker import spq_pkg::*; #(
    parameter int unsigned CAPACITY = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [1:0]                    i_req_type,
    input logic                          o_valid,
    input logic [1:0]                    o_status,
    input logic                          o_found,
    input logic [$clog2(CAPACITY+1)-1:0] o_occupancy
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    // insert and pop answer in the very next cycle
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == REQ_INSERT || i_req_type == REQ_POP))
        |=> o_valid)
        else $error("insert or pop gave no result in the next cycle");

    // a result only follows a taken transaction or the end of a walk
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start) || $past(busy)))
        else $error("result without a pending transaction");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_FULL) |-> (o_occupancy == CNT_W'(CAPACITY)))
        else $error("full status with queue not full");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_EMPTY) |-> (o_occupancy == '0))
        else $error("empty status with entries held");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == STAT_OK && o_occupancy != '0))
        else $error("found flag on a bad status or an empty queue");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_req_type  (i_req_type),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_found     (o_found),
    .o_occupancy (o_occupancy)
);

`default_nettype wire
